>>> sv/euler_zyx_to_quaternion_unit_macros.svh
// Assertion macros for the Euler-to-quaternion unit.
// Used by the top level only; no other dependencies.
`ifndef EULER_ZYX_TO_QUATERNION_UNIT_MACROS_SVH
`define EULER_ZYX_TO_QUATERNION_UNIT_MACROS_SVH

// Implication checked every clock, quiet during reset.
`define EZQ_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, checked also during reset.
`define EZQ_ASSERT_NEXT(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) else $error("assertion failed");

`endif

>>> sv/ezq_pkg.sv
// Types and constants for the Euler-to-quaternion unit.
// No dependencies; used by every module of the block.
package ezq_pkg;
  localparam int unsigned CordicSteps = 24;
  localparam int unsigned ProdStages = 5;
  localparam int unsigned Latency = CordicSteps + 1 + ProdStages;
  localparam logic signed [31:0] GainQ30 = 32'sd652032874;
  localparam logic signed [27:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [27:0] PiQ24 = 28'sd52707179;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [27:0] ang_t;

  typedef struct packed {
    q30_t x;
    q30_t y;
    ang_t z;
    logic flip;
  } rot_t;

  function automatic ang_t atan_q24(input logic [4:0] i);
    case (i)
      5'd0: atan_q24 = 28'sd13176795;
      5'd1: atan_q24 = 28'sd7778716;
      5'd2: atan_q24 = 28'sd4110060;
      5'd3: atan_q24 = 28'sd2086331;
      5'd4: atan_q24 = 28'sd1047214;
      5'd5: atan_q24 = 28'sd524117;
      5'd6: atan_q24 = 28'sd262123;
      5'd7: atan_q24 = 28'sd131069;
      default: atan_q24 = ang_t'(28'sd1) <<< (5'd24 - i);
    endcase
  endfunction

  // Q60 product rounded half up to Q30, kept wide.
  function automatic logic signed [32:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    rnd30 = t[62:30];
  endfunction
endpackage

>>> sv/ezq_cordic_cell.sv
// One CORDIC rotation step, registered; three angles side by side.
// Depends on ezq_pkg.
module ezq_cordic_cell
  import ezq_pkg::*;
#(
  parameter logic [4:0] Step = 5'd0
) (
  input  logic clk,
  input  rot_t in_rot [3],
  output rot_t out_rot [3]
);
  rot_t nxt [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nxt[k].flip = in_rot[k].flip;
      if (in_rot[k].z >= 0) begin
        nxt[k].x = in_rot[k].x - (in_rot[k].y >>> Step);
        nxt[k].y = in_rot[k].y + (in_rot[k].x >>> Step);
        nxt[k].z = in_rot[k].z - atan_q24(Step);
      end else begin
        nxt[k].x = in_rot[k].x + (in_rot[k].y >>> Step);
        nxt[k].y = in_rot[k].y - (in_rot[k].x >>> Step);
        nxt[k].z = in_rot[k].z + atan_q24(Step);
      end
    end
  end
  always_ff @(posedge clk) begin
    out_rot <= nxt;
  end
endmodule

>>> sv/ezq_product.sv
// Quaternion product pipeline: yaw*pitch, then times roll, round, saturate.
// Depends on ezq_pkg.
module ezq_product
  import ezq_pkg::*;
(
  input  logic clk,
  input  q30_t cy, sy, cp, sp, cr, sr,
  output logic signed [15:0] qw, qx, qy, qz
);
  logic signed [63:0] p1 [4];
  q30_t cr1, sr1, cr2, sr2;
  logic signed [32:0] a, b, c, d;
  logic signed [63:0] p2 [8];
  logic signed [33:0] s [4];

  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) to_q14 = 16'sd16384;
    else if (r < -34'sd16384) to_q14 = -16'sd16384;
    else to_q14 = r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    p1[0] <= 64'(cy) * 64'(cp);
    p1[1] <= 64'(sy) * 64'(sp);
    p1[2] <= 64'(cy) * 64'(sp);
    p1[3] <= 64'(sy) * 64'(cp);
    cr1 <= cr; sr1 <= sr;
    a <= rnd30(p1[0]);
    b <= -rnd30(p1[1]);
    c <= rnd30(p1[2]);
    d <= rnd30(p1[3]);
    cr2 <= cr1; sr2 <= sr1;
    p2[0] <= 64'(a) * 64'(cr2);
    p2[1] <= 64'(b) * 64'(sr2);
    p2[2] <= 64'(a) * 64'(sr2);
    p2[3] <= 64'(b) * 64'(cr2);
    p2[4] <= 64'(c) * 64'(cr2);
    p2[5] <= 64'(d) * 64'(sr2);
    p2[6] <= 64'(d) * 64'(cr2);
    p2[7] <= 64'(c) * 64'(sr2);
    s[0] <= 34'(rnd30(p2[0])) - 34'(rnd30(p2[1]));
    s[1] <= 34'(rnd30(p2[2])) + 34'(rnd30(p2[3]));
    s[2] <= 34'(rnd30(p2[4])) + 34'(rnd30(p2[5]));
    s[3] <= 34'(rnd30(p2[6])) - 34'(rnd30(p2[7]));
    qw <= to_q14(s[0]);
    qx <= to_q14(s[1]);
    qy <= to_q14(s[2]);
    qz <= to_q14(s[3]);
  end
endmodule

>>> sv/euler_zyx_to_quaternion_unit.sv
// Euler ZYX angles to unit quaternion, fully pipelined.
// Channels: start/busy input beat with yaw, pitch and roll angles (Q3.13);
// result beat marked by done, quat_w..quat_z in Q1.14, held one cycle.
// busy stays low: one beat is taken every cycle.
// Path from the accepting edge to the result: one fold stage,
// 24 CORDIC cells in a row, five product/round stages.
// Throughput: one angle triple per clock, set by the cell chain.
// Reset clears the valid chain, so no done follows reset until new beats.
// The receiver cannot stall; results appear whether or not it listens.
// Depends on ezq_pkg, ezq_cordic_cell, ezq_product and the macro header.
`include "euler_zyx_to_quaternion_unit_macros.svh"
module euler_zyx_to_quaternion_unit
  import ezq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] yaw_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] roll_angle,
  output logic done,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);
  localparam int unsigned Depth = Latency;
  rot_t chain [CordicSteps+1][3];
  logic [Depth-1:0] vld;
  logic signed [15:0] ang [3];
  q30_t cs [3], sn [3];

  assign busy = 1'b0;
  assign ang[0] = yaw_angle;
  assign ang[1] = pitch_angle;
  assign ang[2] = roll_angle;

  // Fold half angle into [-pi/2, pi/2].
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      chain[0][k].x <= GainQ30;
      chain[0][k].y <= '0;
      if (ang_t'(ang[k]) * 28'sd1024 > HalfPiQ24) begin
        chain[0][k].z <= ang_t'(ang[k]) * 28'sd1024 - PiQ24;
        chain[0][k].flip <= 1'b1;
      end else if (ang_t'(ang[k]) * 28'sd1024 < -HalfPiQ24) begin
        chain[0][k].z <= ang_t'(ang[k]) * 28'sd1024 + PiQ24;
        chain[0][k].flip <= 1'b1;
      end else begin
        chain[0][k].z <= ang_t'(ang[k]) * 28'sd1024;
        chain[0][k].flip <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    ezq_cordic_cell #(.Step(5'(g))) u_cell (
      .clk(clk), .in_rot(chain[g]), .out_rot(chain[g+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cs[k] = chain[CordicSteps][k].flip ? -chain[CordicSteps][k].x : chain[CordicSteps][k].x;
      sn[k] = chain[CordicSteps][k].flip ? -chain[CordicSteps][k].y : chain[CordicSteps][k].y;
    end
  end

  ezq_product u_prod (
    .clk(clk), .cy(cs[0]), .sy(sn[0]), .cp(cs[1]), .sp(sn[1]),
    .cr(cs[2]), .sr(sn[2]),
    .qw(quat_w), .qx(quat_x), .qy(quat_y), .qz(quat_z)
  );

  // Advance the valid chain in step with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Depth-2:0], start & ~busy};
    end
  end
  assign done = vld[Depth-1];

  `EZQ_ASSERT_IMPL(a_busy_low, clk, rst, 1'b1, !busy)
  `EZQ_ASSERT_NEXT(a_rst_clear, clk, rst, vld == '0)
  `EZQ_ASSERT_IMPL(a_sat_w, clk, rst, done, quat_w <= 16'sd16384 && quat_w >= -16'sd16384)
endmodule

>>> sim/tb_euler_zyx_to_quaternion_unit.sv
// Testbench for the Euler ZYX to quaternion unit: directed table, then random angles,
// each result checked against a bit-exact fixed-point predictor. Depends on ezq_pkg.
`timescale 1ns / 1ps
module tb_euler_zyx_to_quaternion_unit;
  import ezq_pkg::*;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct {
    logic signed [15:0] yaw, pitch, roll;
    bit known;
    quat_t q;
  } angle_row_t;

  localparam int unsigned NumRandom = 1030;
  localparam longint unsigned AtanTab [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] yaw_angle = '0, pitch_angle = '0, roll_angle = '0;
  logic done;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

  quat_t expected_quats[$];
  int errors = 0;

  euler_zyx_to_quaternion_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .yaw_angle(yaw_angle), .pitch_angle(pitch_angle), .roll_angle(roll_angle),
    .done(done), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
  );

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  // >>> on signed longint floors, matching the shifts of the block
  function automatic longint rnd_shift(input longint v, input int s);
    rnd_shift = (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint mul30(input longint a, input longint b);
    mul30 = rnd_shift(a * b, 30);
  endfunction

  function automatic void half_cos_sin(input logic signed [15:0] ang, output longint c,
                                       output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 1024;
    x = longint'(GainQ30);
    y = 0;
    flip = 0;
    if (z > longint'(HalfPiQ24)) begin
      z -= longint'(PiQ24);
      flip = 1;
    end else if (z < -longint'(HalfPiQ24)) begin
      z += longint'(PiQ24);
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AtanTab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AtanTab[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [15:0] sat_q14(input longint v);
    longint r;
    r = rnd_shift(v, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    sat_q14 = 16'(r);
  endfunction

  function automatic quat_t euler_to_quat(input logic signed [15:0] yaw,
      input logic signed [15:0] pitch, input logic signed [15:0] roll);
    longint cy, sy, cp, sp, cr, sr, a, b, c, d;
    quat_t q;
    half_cos_sin(yaw, cy, sy);
    half_cos_sin(pitch, cp, sp);
    half_cos_sin(roll, cr, sr);
    a = mul30(cy, cp);
    b = -mul30(sy, sp);
    c = mul30(cy, sp);
    d = mul30(sy, cp);
    q.w = sat_q14(mul30(a, cr) - mul30(b, sr));
    q.x = sat_q14(mul30(a, sr) + mul30(b, cr));
    q.y = sat_q14(mul30(c, cr) + mul30(d, sr));
    q.z = sat_q14(mul30(d, cr) - mul30(c, sr));
    return q;
  endfunction

  // Check each done beat against the oldest expectation.
  always @(posedge clk) begin
    quat_t e;
    if (!rst && done) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time,
                 quat_w, quat_x, quat_y, quat_z);
        errors++;
      end else begin
        e = expected_quats.pop_front();
        if (quat_w !== e.w) begin
          $display("%0t: quat_w expected %0d got %0d", $time, e.w, quat_w); errors++;
        end
        if (quat_x !== e.x) begin
          $display("%0t: quat_x expected %0d got %0d", $time, e.x, quat_x); errors++;
        end
        if (quat_y !== e.y) begin
          $display("%0t: quat_y expected %0d got %0d", $time, e.y, quat_y); errors++;
        end
        if (quat_z !== e.z) begin
          $display("%0t: quat_z expected %0d got %0d", $time, e.z, quat_z); errors++;
        end
      end
    end
  end

  // Drive one beat, holding start until the block takes it.
  task automatic send_angles(input logic signed [15:0] yaw,
      input logic signed [15:0] pitch, input logic signed [15:0] roll, input quat_t q);
    start <= 1'b1;
    yaw_angle <= yaw;
    pitch_angle <= pitch;
    roll_angle <= roll;
    do @(posedge clk); while (busy);
    expected_quats.push_back(q);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 1) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: rand_angle = 16'sd25736 + 16'($urandom_range(0, 2)) - 16'sd1; // near pi
      1: rand_angle = -16'sd25736 + 16'($urandom_range(0, 2)) - 16'sd1;
      2: rand_angle = 16'($urandom_range(0, 15)) - 16'sd8;
      default: rand_angle = 16'($urandom);
    endcase
  endfunction

  angle_row_t table_rows[$];

  initial begin
    quat_t q;
    logic signed [15:0] yv, pv, rv;
    // zero angles give identity; others are predicted
    table_rows = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}},
      '{16'sh7FFF, 16'sd0, 16'sd0, 1'b0, '{0, 0, 0, 0}},
      '{-16'sh8000, 16'sd0, 16'sd0, 1'b0, '{0, 0, 0, 0}},
      '{16'sd0, 16'sh7FFF, 16'sd0, 1'b0, '{0, 0, 0, 0}},
      '{16'sd0, -16'sh8000, 16'sd0, 1'b0, '{0, 0, 0, 0}},
      '{16'sd0, 16'sd0, 16'sh7FFF, 1'b0, '{0, 0, 0, 0}},
      '{16'sd0, 16'sd0, -16'sh8000, 1'b0, '{0, 0, 0, 0}},
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '{0, 0, 0, 0}},
      '{-16'sh8000, -16'sh8000, -16'sh8000, 1'b0, '{0, 0, 0, 0}},
      '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '{0, 0, 0, 0}},
      '{16'sd12868, 16'sd12868, 16'sd12868, 1'b0, '{0, 0, 0, 0}},
      '{16'sd12869, -16'sd12869, 16'sd12867, 1'b0, '{0, 0, 0, 0}},
      '{-16'sd12868, 16'sd25736, -16'sd25736, 1'b0, '{0, 0, 0, 0}},
      '{16'sd25736, 16'sd6434, -16'sd6434, 1'b0, '{0, 0, 0, 0}},
      '{16'sh5555, -16'sh5556, 16'sh2AAA, 1'b0, '{0, 0, 0, 0}},
      '{16'sd1, 16'sd1, 16'sd1, 1'b0, '{0, 0, 0, 0}}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i]) begin
      q = table_rows[i].known ? table_rows[i].q :
          euler_to_quat(table_rows[i].yaw, table_rows[i].pitch, table_rows[i].roll);
      send_angles(table_rows[i].yaw, table_rows[i].pitch, table_rows[i].roll, q);
      idle_gap();
    end
    for (int n = 0; n < NumRandom; n++) begin
      // drain the pipe once midway
      if (n == NumRandom / 2) begin
        start <= 1'b0;
        while (expected_quats.size() != 0) @(posedge clk);
      end
      idle_gap();
      yv = rand_angle();
      pv = rand_angle();
      rv = rand_angle();
      send_angles(yv, pv, rv, euler_to_quat(yv, pv, rv));
    end
    start <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

>>> files.f
+incdir+sv
sv/ezq_pkg.sv
sv/ezq_cordic_cell.sv
sv/ezq_product.sv
sv/euler_zyx_to_quaternion_unit.sv
sim/tb_euler_zyx_to_quaternion_unit.sv
